// ----- design/srp_pkg.sv -----
// Package for the snapshot record parser: result type, phase and token codes,
// magic table and the byte-wide reflected CRC-64 update (ECMA-182 polynomial). No dependencies.
package srp_pkg;

  localparam int CNT_W = 32;               // width of the saturating byte count
  localparam logic [63:0] CRC_POLY = 64'hC96C5795D7870F42;
  localparam int MAGIC_LEN = 15;

  localparam logic [7:0] OP_END    = 8'hFF;
  localparam logic [7:0] OP_EXPIRE = 8'hFD;
  localparam logic [7:0] KIND_STRING = 8'h00;
  localparam logic [7:0] KIND_LIST   = 8'h01;
  localparam logic [7:0] KIND_HASH   = 8'h02;

  localparam logic [3:0] PH_MAGIC    = 4'd0;
  localparam logic [3:0] PH_OP       = 4'd1;
  localparam logic [3:0] PH_EXPIRE   = 4'd2;
  localparam logic [3:0] PH_TYPE     = 4'd3;
  localparam logic [3:0] PH_KEY_LEN  = 4'd4;
  localparam logic [3:0] PH_KEY_BODY = 4'd5;
  localparam logic [3:0] PH_COUNT    = 4'd6;
  localparam logic [3:0] PH_VAL_LEN  = 4'd7;
  localparam logic [3:0] PH_VAL_BODY = 4'd8;
  localparam logic [3:0] PH_STOP     = 4'd9;

  localparam logic [2:0] TK_EXPIRE = 3'd0;
  localparam logic [2:0] TK_TYPE   = 3'd1;
  localparam logic [2:0] TK_COUNT  = 3'd2;
  localparam logic [2:0] TK_STRLEN = 3'd3;
  localparam logic [2:0] TK_STRBYTE = 3'd4;
  localparam logic [2:0] TK_END    = 3'd5;
  localparam logic [2:0] TK_STATUS = 3'd6;

  localparam logic [2:0] ROLE_KEY   = 3'd0;
  localparam logic [2:0] ROLE_VALUE = 3'd1;
  localparam logic [2:0] ROLE_LIST  = 3'd2;
  localparam logic [2:0] ROLE_FIELD = 3'd3;
  localparam logic [2:0] ROLE_HVAL  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd4;

  localparam logic [7:0] MAGIC_TAB [MAGIC_LEN] = '{
    8'h52, 8'h45, 8'h44, 8'h49, 8'h53, 8'h2D, 8'h54, 8'h45,
    8'h41, 8'h43, 8'h48, 8'h30, 8'h30, 8'h30, 8'h31
  };

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  string_role;
    logic [63:0] token_value;
    logic        final_item;
    logic [2:0]  load_status;
  } res_t;

  function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
    logic [63:0] c;
    c = crc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/snapshot_record_parser_crc64_unit.sv -----
// Snapshot file checker and record tokenizer, top level.
// Instantiates srp_parser and srp_out_queue; types from srp_pkg.
//
// Input channel: one file byte per request (data_byte, last_byte marks the
// final byte), in_valid / in_stall. Output channel: one token per request,
// out_valid / out_stall, fields token_kind, string_role, token_value,
// final_item, load_status.
// The last eight bytes of a file are held back as the stored CRC-64; each
// earlier byte goes through the CRC and the record decoder when the eighth
// byte after it is accepted. A byte makes zero or one token; the last byte also makes the final
// status token, after which the parser is back in its reset state.
// Throughput: one byte per cycle while in_stall is low; the decode step is combinational.
// Each token is registered into the queue when its byte is accepted; the
// status token is queued in the same cycle, directly behind the last byte's token.
// Tokens pass through a four-entry queue; in_stall rises when fewer than two
// entries are free, so a stalled receiver holds up the input once three or
// four tokens are queued. Tokens stay provisional until the final status.
// Reset (synchronous, rst high) empties the queue and clears the parser.
module snapshot_record_parser_crc64_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [2:0]  string_role,
  output logic [63:0] token_value,
  output logic        final_item,
  output logic [2:0]  load_status
);

  logic          room;
  logic          step;
  logic [1:0]    push_count;
  srp_pkg::res_t item0;
  srp_pkg::res_t item1;
  srp_pkg::res_t head;

  assign in_stall = !room;
  assign step     = in_valid && room;

  srp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push_count (push_count),
    .item0      (item0),
    .item1      (item1)
  );

  srp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .item0      (item0),
    .item1      (item1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  assign token_kind  = head.token_kind;
  assign string_role = head.string_role;
  assign token_value = head.token_value;
  assign final_item  = head.final_item;
  assign load_status = head.load_status;

endmodule

// ----- design/srp_parser.sv -----
// Per-byte step: holdback line, CRC, record decoder and final status.
// Produces up to two result requests per accepted byte. Uses srp_pkg.
module srp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic [1:0]       push_count,
  output srp_pkg::res_t    item0,
  output srp_pkg::res_t    item1
);

  logic [7:0]  hold [8];
  logic [63:0] crc;
  logic [srp_pkg::CNT_W-1:0] cnt;
  logic [3:0]  phase;
  logic [63:0] acc;
  logic [2:0]  idx;
  logic [31:0] srem;
  logic [31:0] erem;
  logic [7:0]  kind;
  logic        hvn;
  logic [2:0]  err;
  logic        ends;
  logic        mm;

  logic [63:0] crc_next;
  logic [srp_pkg::CNT_W-1:0] cnt_next;
  logic [3:0]  phase_next;
  logic [63:0] acc_next;
  logic [2:0]  idx_next;
  logic [31:0] srem_next;
  logic [31:0] erem_next;
  logic [7:0]  kind_next;
  logic        hvn_next;
  logic [2:0]  err_next;
  logic        ends_next;
  logic        mm_next;

  logic        tok_v;
  srp_pkg::res_t tok;
  srp_pkg::res_t fin;
  logic [7:0]  rel;
  logic        active;
  logic [srp_pkg::CNT_W-1:0] cnt_m8;
  logic [3:0]  midx;
  logic [63:0] stored;
  logic        do_after_key;
  logic        do_after_value;
  logic [2:0]  vrole;
  logic [31:0] v32;
  logic [2:0]  status;

  localparam logic [srp_pkg::CNT_W-1:0] CNT_MAX = '1;

  assign rel    = hold[0];
  assign active = cnt >= srp_pkg::CNT_W'(8);
  assign cnt_m8 = cnt - srp_pkg::CNT_W'(8);
  assign midx   = cnt_m8[3:0];
  assign stored = {data_byte, hold[7], hold[6], hold[5], hold[4], hold[3], hold[2], hold[1]};

  always_comb begin
    priority if (kind == srp_pkg::KIND_STRING) vrole = srp_pkg::ROLE_VALUE;
    else if (kind == srp_pkg::KIND_LIST) vrole = srp_pkg::ROLE_LIST;
    else vrole = hvn ? srp_pkg::ROLE_HVAL : srp_pkg::ROLE_FIELD;
  end

  always_comb begin
    crc_next   = crc;
    phase_next = phase;
    acc_next   = acc;
    idx_next   = idx;
    srem_next  = srem;
    erem_next  = erem;
    kind_next  = kind;
    hvn_next   = hvn;
    err_next   = err;
    ends_next  = ends;
    mm_next    = mm;
    tok_v      = 1'b0;
    tok        = '0;
    do_after_key   = 1'b0;
    do_after_value = 1'b0;
    v32        = 32'd0;
    cnt_next   = (cnt != CNT_MAX) ? cnt + srp_pkg::CNT_W'(1) : cnt;

    if (active) begin
      crc_next = srp_pkg::crc64_byte(crc, rel);
      unique case (phase)
        srp_pkg::PH_MAGIC: begin
          if (midx < 4'(srp_pkg::MAGIC_LEN) && rel != srp_pkg::MAGIC_TAB[midx]) mm_next = 1'b0;
          if (midx == 4'(srp_pkg::MAGIC_LEN - 1)) begin
            if (mm_next) begin
              phase_next = srp_pkg::PH_OP;
              acc_next = '0;
              idx_next = '0;
            end else begin
              phase_next = srp_pkg::PH_STOP;
            end
          end
        end
        srp_pkg::PH_OP, srp_pkg::PH_TYPE: begin
          if (phase == srp_pkg::PH_OP && rel == srp_pkg::OP_END) begin
            ends_next  = 1'b1;
            phase_next = srp_pkg::PH_STOP;
            tok_v = 1'b1;
            tok.token_kind = srp_pkg::TK_END;
          end else if (phase == srp_pkg::PH_OP && rel == srp_pkg::OP_EXPIRE) begin
            phase_next = srp_pkg::PH_EXPIRE;
            acc_next = '0;
            idx_next = '0;
          end else begin
            kind_next  = rel;
            phase_next = srp_pkg::PH_KEY_LEN;
            acc_next = '0;
            idx_next = '0;
            tok_v = 1'b1;
            tok.token_kind  = srp_pkg::TK_TYPE;
            tok.token_value = {56'd0, rel};
          end
        end
        srp_pkg::PH_EXPIRE: begin
          acc_next = acc | ({56'd0, rel} << {idx, 3'b000});
          if (idx == 3'd7) begin
            tok_v = 1'b1;
            tok.token_kind  = srp_pkg::TK_EXPIRE;
            tok.token_value = acc_next;
            phase_next = srp_pkg::PH_TYPE;
            acc_next = '0;
            idx_next = '0;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        srp_pkg::PH_KEY_LEN, srp_pkg::PH_VAL_LEN, srp_pkg::PH_COUNT: begin
          acc_next = acc | ({56'd0, rel} << {idx[1:0], 3'b000});
          if (idx < 3'd3) begin
            idx_next = idx + 3'd1;
          end else begin
            v32 = acc_next[31:0];
            acc_next = '0;
            idx_next = '0;
            tok_v = 1'b1;
            tok.token_value = {32'd0, v32};
            if (phase == srp_pkg::PH_COUNT) begin
              tok.token_kind = srp_pkg::TK_COUNT;
              erem_next  = v32;
              hvn_next   = 1'b0;
              phase_next = (v32 == 32'd0) ? srp_pkg::PH_OP : srp_pkg::PH_VAL_LEN;
            end else begin
              tok.token_kind  = srp_pkg::TK_STRLEN;
              tok.string_role = (phase == srp_pkg::PH_KEY_LEN) ? srp_pkg::ROLE_KEY : vrole;
              srem_next = v32;
              if (v32 != 32'd0) begin
                phase_next = (phase == srp_pkg::PH_KEY_LEN) ? srp_pkg::PH_KEY_BODY
                                                           : srp_pkg::PH_VAL_BODY;
              end else if (phase == srp_pkg::PH_KEY_LEN) begin
                do_after_key = 1'b1;
              end else begin
                do_after_value = 1'b1;
              end
            end
          end
        end
        srp_pkg::PH_KEY_BODY, srp_pkg::PH_VAL_BODY: begin
          tok_v = 1'b1;
          tok.token_kind  = srp_pkg::TK_STRBYTE;
          tok.string_role = (phase == srp_pkg::PH_KEY_BODY) ? srp_pkg::ROLE_KEY : vrole;
          tok.token_value = {56'd0, rel};
          srem_next = srem - 32'd1;
          if (srem_next == 32'd0) begin
            if (phase == srp_pkg::PH_KEY_BODY) do_after_key = 1'b1;
            else do_after_value = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_after_key) begin
        acc_next = '0;
        idx_next = '0;
        priority if (kind_next == srp_pkg::KIND_STRING) phase_next = srp_pkg::PH_VAL_LEN;
        else if (kind_next == srp_pkg::KIND_LIST || kind_next == srp_pkg::KIND_HASH)
          phase_next = srp_pkg::PH_COUNT;
        else begin
          err_next   = srp_pkg::ST_BAD_TYPE;
          phase_next = srp_pkg::PH_STOP;
        end
      end
      if (do_after_value) begin
        acc_next = '0;
        idx_next = '0;
        priority if (kind == srp_pkg::KIND_STRING) phase_next = srp_pkg::PH_OP;
        else if (kind == srp_pkg::KIND_HASH && !hvn) begin
          hvn_next   = 1'b1;
          phase_next = srp_pkg::PH_VAL_LEN;
        end else begin
          hvn_next   = 1'b0;
          erem_next  = erem - 32'd1;
          phase_next = (erem_next == 32'd0) ? srp_pkg::PH_OP : srp_pkg::PH_VAL_LEN;
        end
      end
    end
  end

  always_comb begin
    priority if (cnt_next < srp_pkg::CNT_W'(24) || !mm_next) status = srp_pkg::ST_BAD_MAGIC;
    else if (cnt_next == CNT_MAX) status = srp_pkg::ST_TRUNC;
    else if (crc_next != stored) status = srp_pkg::ST_CRC;
    else if (err_next != srp_pkg::ST_OK) status = err_next;
    else if (!ends_next) status = srp_pkg::ST_TRUNC;
    else status = srp_pkg::ST_OK;
    fin = '0;
    fin.token_kind  = srp_pkg::TK_STATUS;
    fin.token_value = {61'd0, status};
    fin.final_item  = 1'b1;
    fin.load_status = status;
  end

  // results are compacted: slot 0 gets whichever comes first
  always_comb begin
    push_count = '0;
    item0 = tok;
    item1 = fin;
    if (step) begin
      if (tok_v && last_byte) push_count = 2'd2;
      else if (tok_v) push_count = 2'd1;
      else if (last_byte) begin
        push_count = 2'd1;
        item0 = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      for (int i = 0; i < 8; i++) hold[i] <= '0;
      crc   <= '0;
      cnt   <= '0;
      phase <= srp_pkg::PH_MAGIC;
      acc   <= '0;
      idx   <= '0;
      srem  <= '0;
      erem  <= '0;
      kind  <= '0;
      hvn   <= 1'b0;
      err   <= srp_pkg::ST_OK;
      ends  <= 1'b0;
      mm    <= 1'b1;
    end else if (step) begin
      for (int i = 0; i < 7; i++) hold[i] <= hold[i+1];
      hold[7] <= data_byte;
      crc   <= crc_next;
      cnt   <= cnt_next;
      phase <= phase_next;
      acc   <= acc_next;
      idx   <= idx_next;
      srem  <= srem_next;
      erem  <= erem_next;
      kind  <= kind_next;
      hvn   <= hvn_next;
      err   <= err_next;
      ends  <= ends_next;
      mm    <= mm_next;
    end
  end

endmodule

// ----- design/srp_out_queue.sv -----
// Four-entry result queue between the byte step and the output channel.
// Takes up to two requests per cycle, hands out one while out_stall is low. Uses srp_pkg.
module srp_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_count,
  input  srp_pkg::res_t item0,
  input  srp_pkg::res_t item1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output srp_pkg::res_t head
);

  srp_pkg::res_t slots [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop  = out_valid && !out_stall;
  assign room = count <= 3'd2;   // space for two more
  assign head = slots[rp];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wp] <= item0;
    if (push_count == 2'd2) slots[wp + 2'd1] <= item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_count;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push_count} - {2'b0, pop};
    end
  end

endmodule

// ----- design/srp_checker.sv -----
// Port-level checks for snapshot_record_parser_crc64_unit, with its bind.
// Uses srp_pkg codes.
module srp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  token_kind,
  input logic [2:0]  string_role,
  input logic [63:0] token_value,
  input logic        final_item,
  input logic [2:0]  load_status
);

  // a held token stays valid and keeps its kind and value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_value) && $stable(token_kind))
    else $error("stalled token changed");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_item |->
      token_kind == srp_pkg::TK_STATUS && token_value == {61'd0, load_status})
    else $error("final status token malformed");

  a_status_only_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_item |-> load_status == srp_pkg::ST_OK &&
      token_kind != srp_pkg::TK_STATUS)
    else $error("status on non-final token");

  a_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != srp_pkg::TK_STRLEN && token_kind != srp_pkg::TK_STRBYTE
      |-> string_role == srp_pkg::ROLE_KEY)
    else $error("role set on non-string token");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind snapshot_record_parser_crc64_unit srp_checker u_srp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .token_kind  (token_kind),
  .string_role (string_role),
  .token_value (token_value),
  .final_item  (final_item),
  .load_status (load_status)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for snapshot_record_parser_crc64_unit: builds snapshot files, streams them
// byte by byte and checks every token against a local parser/CRC model. Uses srp_pkg.
module testbench;

  localparam int LIMIT = 600000;
  localparam logic [63:0] CNT_MAX = (64'd1 << srp_pkg::CNT_W) - 64'd1;

  localparam int MODE_GOOD = 0;
  localparam int MODE_CRC = 1;
  localparam int MODE_TRUNC = 2;
  localparam int MODE_MAGIC = 3;
  localparam int MODE_UNKNOWN = 4;
  localparam int MODE_NOISE = 5;
  localparam int MODE_NOEND = 6;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  data_byte = 0;
  logic        last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  token_kind;
  logic [2:0]  string_role;
  logic [63:0] token_value;
  logic        final_item;
  logic [2:0]  load_status;

  snapshot_record_parser_crc64_unit uut (.*);

  always #6 clk = ~clk;

  // model state
  logic [7:0]  hold_q [8];
  logic [63:0] crc_acc;
  logic [63:0] byte_count;
  logic [3:0]  phase;
  logic [63:0] field_val;
  logic [2:0]  field_idx;
  logic [31:0] str_left;
  logic [31:0] elem_left;
  logic [7:0]  rec_kind;
  logic        hval_next;
  logic [2:0]  err_code;
  logic        saw_end;
  logic        magic_ok;

  srp_pkg::res_t pending_tokens [$];
  logic [7:0] file_bytes [$];

  int errors = 0;
  int cycles = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_go = 0;

  function automatic logic [63:0] crc_next(logic [63:0] c, logic [7:0] b);
    c ^= {56'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ srp_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < 8; i++) hold_q[i] = 8'd0;
    crc_acc = '0; byte_count = '0; phase = srp_pkg::PH_MAGIC; field_val = '0;
    field_idx = '0; str_left = '0; elem_left = '0; rec_kind = '0; hval_next = 1'b0;
    err_code = srp_pkg::ST_OK; saw_end = 1'b0; magic_ok = 1'b1;
  endtask

  task automatic push_token(logic [2:0] k, logic [2:0] r, logic [63:0] v);
    srp_pkg::res_t t;
    t = '{token_kind: k, string_role: r, token_value: v, final_item: 1'b0,
          load_status: srp_pkg::ST_OK};
    pending_tokens.push_back(t);
  endtask

  task automatic begin_field(logic [3:0] ph);
    phase = ph; field_val = '0; field_idx = '0;
  endtask

  function automatic logic [2:0] body_role();
    if (rec_kind == srp_pkg::KIND_STRING) return srp_pkg::ROLE_VALUE;
    if (rec_kind == srp_pkg::KIND_LIST) return srp_pkg::ROLE_LIST;
    return hval_next ? srp_pkg::ROLE_HVAL : srp_pkg::ROLE_FIELD;
  endfunction

  task automatic key_done();
    if (rec_kind == srp_pkg::KIND_STRING) begin_field(srp_pkg::PH_VAL_LEN);
    else if (rec_kind == srp_pkg::KIND_LIST || rec_kind == srp_pkg::KIND_HASH)
      begin_field(srp_pkg::PH_COUNT);
    else begin
      err_code = srp_pkg::ST_BAD_TYPE;
      phase = srp_pkg::PH_STOP;
    end
  endtask

  task automatic value_done();
    if (rec_kind == srp_pkg::KIND_STRING) begin
      begin_field(srp_pkg::PH_OP);
    end else if (rec_kind == srp_pkg::KIND_HASH && !hval_next) begin
      hval_next = 1'b1;
      begin_field(srp_pkg::PH_VAL_LEN);
    end else begin
      hval_next = 1'b0;
      elem_left--;
      begin_field(elem_left == 32'd0 ? srp_pkg::PH_OP : srp_pkg::PH_VAL_LEN);
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic [63:0] pos);
    int idx;
    logic [31:0] v;
    logic [3:0] ph;
    ph = phase;
    case (ph)
      srp_pkg::PH_MAGIC: begin
        idx = pos < srp_pkg::MAGIC_LEN ? int'(pos) : srp_pkg::MAGIC_LEN - 1;
        if (b != srp_pkg::MAGIC_TAB[idx]) magic_ok = 1'b0;
        if (idx == srp_pkg::MAGIC_LEN - 1) begin
          if (magic_ok) begin_field(srp_pkg::PH_OP);
          else phase = srp_pkg::PH_STOP;
        end
      end
      srp_pkg::PH_OP, srp_pkg::PH_TYPE: begin
        if (ph == srp_pkg::PH_OP && b == srp_pkg::OP_END) begin
          saw_end = 1'b1;
          phase = srp_pkg::PH_STOP;
          push_token(srp_pkg::TK_END, srp_pkg::ROLE_KEY, 64'd0);
        end else if (ph == srp_pkg::PH_OP && b == srp_pkg::OP_EXPIRE) begin
          begin_field(srp_pkg::PH_EXPIRE);
        end else begin
          rec_kind = b;
          begin_field(srp_pkg::PH_KEY_LEN);
          push_token(srp_pkg::TK_TYPE, srp_pkg::ROLE_KEY, {56'd0, b});
        end
      end
      srp_pkg::PH_EXPIRE: begin
        field_val |= {56'd0, b} << (8 * field_idx);
        if (field_idx == 3'd7) begin
          push_token(srp_pkg::TK_EXPIRE, srp_pkg::ROLE_KEY, field_val);
          begin_field(srp_pkg::PH_TYPE);
        end else field_idx++;
      end
      srp_pkg::PH_KEY_LEN, srp_pkg::PH_VAL_LEN, srp_pkg::PH_COUNT: begin
        field_val |= {56'd0, b} << (8 * field_idx[1:0]);
        if (field_idx < 3'd3) field_idx++;
        else begin
          v = field_val[31:0];
          if (ph == srp_pkg::PH_COUNT) begin
            push_token(srp_pkg::TK_COUNT, srp_pkg::ROLE_KEY, {32'd0, v});
            elem_left = v;
            hval_next = 1'b0;
            begin_field(v == 32'd0 ? srp_pkg::PH_OP : srp_pkg::PH_VAL_LEN);
          end else begin
            push_token(srp_pkg::TK_STRLEN,
                       ph == srp_pkg::PH_KEY_LEN ? srp_pkg::ROLE_KEY : body_role(),
                       {32'd0, v});
            str_left = v;
            if (v != 32'd0)
              phase = (ph == srp_pkg::PH_KEY_LEN) ? srp_pkg::PH_KEY_BODY : srp_pkg::PH_VAL_BODY;
            else if (ph == srp_pkg::PH_KEY_LEN) key_done();
            else value_done();
          end
        end
      end
      srp_pkg::PH_KEY_BODY, srp_pkg::PH_VAL_BODY: begin
        push_token(srp_pkg::TK_STRBYTE,
                   ph == srp_pkg::PH_KEY_BODY ? srp_pkg::ROLE_KEY : body_role(), {56'd0, b});
        str_left--;
        if (str_left == 32'd0) begin
          if (ph == srp_pkg::PH_KEY_BODY) key_done();
          else value_done();
        end
      end
      default: ;
    endcase
  endtask

  // one accepted request: holdback shift, CRC, decode, final status
  task automatic parse_file_byte(logic [7:0] b, logic l);
    logic [7:0] rel;
    logic [63:0] pre, stored;
    logic [2:0] st;
    srp_pkg::res_t t;
    pre = byte_count;
    rel = hold_q[0];
    for (int i = 0; i < 7; i++) hold_q[i] = hold_q[i + 1];
    hold_q[7] = b;
    if (pre >= 64'd8) begin
      crc_acc = crc_next(crc_acc, rel);
      decode_byte(rel, pre - 64'd8);
    end
    if (pre < CNT_MAX) byte_count = pre + 64'd1;
    if (l) begin
      stored = '0;
      for (int i = 0; i < 8; i++) stored |= {56'd0, hold_q[i]} << (8 * i);
      if (byte_count < 64'(srp_pkg::MAGIC_LEN + 9) || !magic_ok) st = srp_pkg::ST_BAD_MAGIC;
      else if (byte_count >= CNT_MAX) st = srp_pkg::ST_TRUNC;
      else if (crc_acc != stored) st = srp_pkg::ST_CRC;
      else if (err_code != srp_pkg::ST_OK) st = err_code;
      else if (!saw_end) st = srp_pkg::ST_TRUNC;
      else st = srp_pkg::ST_OK;
      t = '{token_kind: srp_pkg::TK_STATUS, string_role: srp_pkg::ROLE_KEY,
            token_value: {61'd0, st}, final_item: 1'b1, load_status: st};
      pending_tokens.push_back(t);
      clear_model();
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s at cycle %0d: got %0h, want %0h", what, cycles, got, want);
  endtask

  // token checker and receiver stall
  always @(posedge clk) begin
    srp_pkg::res_t w;
    if (!rst && out_valid && !out_stall) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) report("unexpected token", {61'd0, token_kind}, 64'd0);
      else begin
        w = pending_tokens.pop_front();
        if (token_kind !== w.token_kind)
          report("token_kind", {61'd0, token_kind}, {61'd0, w.token_kind});
        if (string_role !== w.string_role)
          report("string_role", {61'd0, string_role}, {61'd0, w.string_role});
        if (token_value !== w.token_value) report("token_value", token_value, w.token_value);
        if (final_item !== w.final_item)
          report("final_item", {63'd0, final_item}, {63'd0, w.final_item});
        if (load_status !== w.load_status)
          report("load_status", {61'd0, load_status}, {61'd0, w.load_status});
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 400;
      hold_go = 1'b0;
    end else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("snapshot_record_parser_crc64_unit verification failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!(in_valid && !in_stall));
    parse_file_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_string(int max_len);
    int n;
    n = int'($urandom_range(max_len));
    put32(n);
    repeat (n) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_expire();
    file_bytes.push_back(srp_pkg::OP_EXPIRE);
    put32($urandom);
    put32($urandom);
  endtask

  task automatic put_record();
    logic [7:0] k;
    int n;
    if ($urandom_range(1)) put_expire();
    k = 8'($urandom_range(2));
    file_bytes.push_back(k);
    put_string(4);
    if (k == srp_pkg::KIND_STRING) put_string(5);
    else begin
      n = int'($urandom_range(3));
      put32(n);
      repeat (k == srp_pkg::KIND_HASH ? 2 * n : n) put_string(4);
    end
  endtask

  task automatic make_file(int mode, int nrec);
    logic [63:0] c;
    int cut;
    file_bytes.delete();
    if (mode == MODE_NOISE) begin
      repeat ($urandom_range(40, 1)) file_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    for (int i = 0; i < srp_pkg::MAGIC_LEN; i++) file_bytes.push_back(srp_pkg::MAGIC_TAB[i]);
    if (mode == MODE_MAGIC) file_bytes[$urandom_range(14)] ^= 8'd1 << $urandom_range(7);
    repeat (nrec) put_record();
    if (mode == MODE_UNKNOWN) begin
      // after an expire even the end and expire opcodes are taken as a type
      put_expire();
      case ($urandom_range(2))
        0: file_bytes.push_back(srp_pkg::OP_END);
        1: file_bytes.push_back(srp_pkg::OP_EXPIRE);
        default: file_bytes.push_back(8'($urandom_range(8'hFC, 3)));
      endcase
      put_string(3);
      repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom_range(255)));
    end
    if (mode != MODE_NOEND) file_bytes.push_back(srp_pkg::OP_END);
    // bytes after the end opcode only feed the CRC
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) file_bytes.push_back(8'($urandom));
    if (mode == MODE_TRUNC && file_bytes.size() > 16) begin
      cut = int'($urandom_range(file_bytes.size() - 1, 16));
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    c = '0;
    foreach (file_bytes[i]) c = crc_next(c, file_bytes[i]);
    for (int i = 0; i < 8; i++) file_bytes.push_back(c[8*i +: 8]);
    if (mode == MODE_CRC)
      file_bytes[file_bytes.size() - 1 - $urandom_range(7)] ^= 8'd1 << $urandom_range(7);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    file_bytes.delete();
    repeat (5) file_bytes.push_back(8'($urandom));
    send_file();                               // too short
    make_file(MODE_GOOD, 0); send_file();      // magic, end, crc, no records
    make_file(MODE_GOOD, 3); send_file();
    make_file(MODE_CRC, 1); send_file();
    make_file(MODE_MAGIC, 1); send_file();
    make_file(MODE_UNKNOWN, 0); send_file();
    make_file(MODE_NOEND, 1); send_file();
    make_file(MODE_TRUNC, 2); send_file();
    // string length of all ones, file ends inside the key
    make_file(MODE_GOOD, 0);
    file_bytes = file_bytes[0:14];
    file_bytes.push_back(srp_pkg::KIND_HASH);
    put32(32'hFFFF_FFFF);
    repeat (8) file_bytes.push_back(8'($urandom));
    send_file();
    drain();
  endtask

  task automatic random_files(int byte_quota);
    int stop_at, r, mode;
    stop_at = bytes_sent + byte_quota;
    while (bytes_sent < stop_at) begin
      r = int'($urandom_range(99));
      mode = r < 55 ? MODE_GOOD : r < 62 ? MODE_CRC : r < 70 ? MODE_TRUNC :
             r < 76 ? MODE_MAGIC : r < 84 ? MODE_UNKNOWN : r < 92 ? MODE_NOISE : MODE_NOEND;
      make_file(mode, int'($urandom_range(3)));
      send_file();
    end
  endtask

  task automatic test_random_phases();
    idle_pct = 0;  stall_pct = 0;  random_files(300);
    idle_pct = 85; stall_pct = 0;  random_files(250);
    idle_pct = 0;  stall_pct = 85; random_files(250);
    idle_pct = 27; stall_pct = 27; random_files(300);
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    make_file(MODE_GOOD, 3);
    send_file();
    make_file(MODE_GOOD, 2);
    send_file();
    drain();
  endtask

  initial begin
    clear_model();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    repeat (10) @(posedge clk);
    $display("sent %0d files, %0d bytes; checked %0d tokens", files_sent, bytes_sent,
             tokens_seen);
    $display("covered good, crc, truncated, bad magic, unknown type, noise and stall phases");
    if (errors == 0 && pending_tokens.size() == 0)
      $display("snapshot_record_parser_crc64_unit verification clean");
    else
      $display("snapshot_record_parser_crc64_unit verification failed");
    $finish;
  end

endmodule
